/* design/oaht_pkg.sv */
// shared types and constants of the open addressing hash table core
package oaht_pkg;

    // fixed field widths
    localparam int KEY_W      = 31;
    localparam int MODE_W     = 2;
    localparam int CODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int FOUND_PAY_W = 32;

    // multiplicative hash constant and probe step
    localparam logic [31:0] HASH_MULT  = 32'd2654435769;
    localparam int          PROBE_STEP = 5;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WITHDRAW = 2'd2;

    // slot status codes
    localparam logic [STATUS_W-1:0] SLOT_FREE     = 2'd0;
    localparam logic [STATUS_W-1:0] SLOT_DELETED  = 2'd1;
    localparam logic [STATUS_W-1:0] SLOT_OCCUPIED = 2'd2;

    // result codes
    localparam logic [CODE_W-1:0] RC_DONE      = 3'd0;
    localparam logic [CODE_W-1:0] RC_FULL      = 3'd1;
    localparam logic [CODE_W-1:0] RC_NO_SLOT   = 3'd2;
    localparam logic [CODE_W-1:0] RC_NOT_FOUND = 3'd3;
    localparam logic [CODE_W-1:0] RC_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RESP
    } state_t;

    // commands from the sequencer to the probe generator
    typedef struct packed {
        logic start;
        logic advance;
    } probe_ctl_t;

endpackage

/* design/oaht_slot_ram.sv */
// slot memory: status, key and payload of every slot, one write and one registered read port
module oaht_slot_ram import oaht_pkg::*; #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 65
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/oaht_probe_gen.sv */
// probe address unit: hash of the key, then quadratic offsets by running sums
module oaht_probe_gen import oaht_pkg::*; #(
    parameter int TABLE_BITS = 13
) (
    input  logic                  aclk,
    input  probe_ctl_t            ctl,
    input  logic [KEY_W-1:0]      key,
    output logic [TABLE_BITS-1:0] addr,
    output logic                  last
);

    logic [31:0]           prod;
    logic [TABLE_BITS-1:0] home_reg, home_next;
    logic [TABLE_BITS-1:0] off_reg, off_next;
    logic [TABLE_BITS-1:0] delta_reg, delta_next;
    logic [TABLE_BITS-1:0] idx_reg, idx_next;

    // key * constant mod 2^32, the top bits give the home slot
    assign prod = 32'({1'b0, key} * HASH_MULT);

    // off(i) = 5*i*i, delta(i) = 5*(2i+1); all mod table size
    always_comb begin
        home_next  = home_reg;
        off_next   = off_reg;
        delta_next = delta_reg;
        idx_next   = idx_reg;
        if (ctl.start) begin
            home_next  = prod[31 -: TABLE_BITS];
            off_next   = '0;
            delta_next = TABLE_BITS'(PROBE_STEP);
            idx_next   = '0;
        end else if (ctl.advance) begin
            off_next   = off_reg + delta_reg;
            delta_next = delta_reg + TABLE_BITS'(2 * PROBE_STEP);
            idx_next   = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        home_reg  <= home_next;
        off_reg   <= off_next;
        delta_reg <= delta_next;
        idx_reg   <= idx_next;
    end

    assign addr = home_reg + off_reg;
    assign last = &idx_reg;

endmodule

/* design/open_addressing_hash_table_core.sv */
// top level of the open addressing hash table core with quadratic probing
//
//  channel | dir | tdata (low bit up)                     | tuser
//  --------+-----+----------------------------------------+-------------
//  s_      | in  | key, payload                           | mode
//  m_      | out | slot_index, found_key, found_payload   | result_code
//
// after reset a clearing pass marks all 2^TABLE_BITS slots free, one slot a
// cycle, with s_tready low for the whole pass
// an insert, lookup or withdraw goes through a read and a check state per probe,
// then a response state, set by the one slot memory read port and the probe unit
// a full insert, empty withdraw or unused mode goes straight to the response state
// the result sits in an output register, so a stalled m_ side does not hold
// up the next word on s_ until that word's own result is ready
module open_addressing_hash_table_core import oaht_pkg::*; #(
    parameter int TABLE_BITS   = 13,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((KEY_W+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,   // key, payload
    input  logic [MODE_W-1:0]           s_tuser,               // mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((TABLE_BITS+KEY_W+FOUND_PAY_W+7)/8)*8-1:0] m_tdata,
                                                // slot_index, found_key, found_payload
    output logic [CODE_W-1:0]           m_tuser                // result_code
);

    localparam int IN_W   = ((KEY_W + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int OUT_W  = ((TABLE_BITS + KEY_W + FOUND_PAY_W + 7) / 8) * 8;
    localparam int WORD_W = STATUS_W + KEY_W + PAYLOAD_BITS;
    localparam int OUT_PAD = OUT_W - TABLE_BITS - KEY_W - FOUND_PAY_W;
    localparam logic [TABLE_BITS:0] SLOTS_CNT = {1'b1, {TABLE_BITS{1'b0}}};

    // sequencer and item registers
    state_t                  state_reg, state_next;
    logic [TABLE_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [TABLE_BITS:0]     count_reg, count_next;
    logic [MODE_W-1:0]       mode_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    // staged result
    logic [CODE_W-1:0]       res_code_reg, res_code_next;
    logic [TABLE_BITS-1:0]   res_idx_reg, res_idx_next;
    logic [KEY_W-1:0]        res_key_reg, res_key_next;
    logic [FOUND_PAY_W-1:0]  res_pay_reg, res_pay_next;

    // output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [CODE_W-1:0]       m_code_reg;
    logic [TABLE_BITS-1:0]   m_idx_reg;
    logic [KEY_W-1:0]        m_key_reg;
    logic [FOUND_PAY_W-1:0]  m_pay_reg;

    // slot memory and probe unit connections
    logic                    mem_we;
    logic [TABLE_BITS-1:0]   mem_waddr;
    logic [WORD_W-1:0]       mem_wdata;
    logic [WORD_W-1:0]       mem_rdata;
    probe_ctl_t              probe_ctl;
    logic [TABLE_BITS-1:0]   probe_addr;
    logic                    probe_last;

    // fields of the slot just read
    logic [STATUS_W-1:0]     rd_status;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [63:0]             rd_pay_wide;

    logic in_fire;
    logic out_free;
    logic ins_take;
    logic srch_hit;
    logic srch_stop;
    logic check_done;

    oaht_slot_ram #(
        .ADDR_W (TABLE_BITS),
        .DATA_W (WORD_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (probe_addr),
        .rdata (mem_rdata)
    );

    oaht_probe_gen #(
        .TABLE_BITS (TABLE_BITS)
    ) u_probe (
        .aclk (aclk),
        .ctl  (probe_ctl),
        .key  (s_tdata[KEY_W-1:0]),
        .addr (probe_addr),
        .last (probe_last)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;

    // slot word: status on top, then key, payload in the low bits
    assign rd_status   = mem_rdata[WORD_W-1 -: STATUS_W];
    assign rd_key      = mem_rdata[PAYLOAD_BITS +: KEY_W];
    assign rd_pay      = mem_rdata[PAYLOAD_BITS-1:0];
    assign rd_pay_wide = 64'(rd_pay);

    // probe outcome: insert takes any slot not occupied, searches end on free
    assign ins_take  = (rd_status != SLOT_OCCUPIED);
    assign srch_hit  = (rd_status == SLOT_OCCUPIED) && (rd_key == key_reg);
    assign srch_stop = (rd_status == SLOT_FREE);
    assign check_done = (mode_reg == MODE_INSERT) ? (ins_take | probe_last)
                                                  : (srch_hit | srch_stop | probe_last);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_tuser)
                        MODE_INSERT: begin
                            state_next = (count_reg >= SLOTS_CNT) ? ST_RESP : ST_READ;
                        end
                        MODE_LOOKUP: begin
                            state_next = ST_READ;
                        end
                        MODE_WITHDRAW: begin
                            state_next = (count_reg == '0) ? ST_RESP : ST_READ;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = check_done ? ST_RESP : ST_READ;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath controls, memory writes and result staging
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        count_next    = count_reg;
        mem_we        = 1'b0;
        mem_waddr     = probe_addr;
        mem_wdata     = '0;
        probe_ctl     = '0;
        res_code_next = res_code_reg;
        res_idx_next  = res_idx_reg;
        res_key_next  = res_key_reg;
        res_pay_next  = res_pay_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                // write free status into every slot
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    probe_ctl.start = 1'b1;
                    res_code_next   = RC_DONE;
                    res_idx_next    = '0;
                    res_key_next    = '0;
                    res_pay_next    = '0;
                    case (s_tuser)
                        MODE_INSERT: begin
                            if (count_reg >= SLOTS_CNT) begin
                                res_code_next = RC_FULL;
                            end
                        end
                        MODE_WITHDRAW: begin
                            if (count_reg == '0) begin
                                res_code_next = RC_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
            end
            ST_CHECK: begin
                if (!check_done) begin
                    probe_ctl.advance = 1'b1;
                end
                case (mode_reg)
                    MODE_INSERT: begin
                        if (ins_take) begin
                            mem_we       = 1'b1;
                            mem_wdata    = {SLOT_OCCUPIED, key_reg, pay_reg};
                            count_next   = count_reg + 1'b1;
                            res_idx_next = probe_addr;
                        end else if (probe_last) begin
                            res_code_next = RC_NO_SLOT;
                        end
                    end
                    MODE_LOOKUP: begin
                        if (srch_hit) begin
                            res_idx_next = probe_addr;
                            res_key_next = rd_key;
                            res_pay_next = rd_pay_wide[FOUND_PAY_W-1:0];
                        end else if (srch_stop || probe_last) begin
                            res_code_next = RC_NOT_FOUND;
                        end
                    end
                    default: begin
                        // withdraw: mark the slot deleted, keep its contents
                        if (srch_hit) begin
                            mem_we       = 1'b1;
                            mem_wdata    = {SLOT_DELETED, rd_key, rd_pay};
                            count_next   = count_reg - 1'b1;
                            res_idx_next = probe_addr;
                        end else if (srch_stop || probe_last) begin
                            res_code_next = RC_NOT_FOUND;
                        end
                    end
                endcase
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // output register handshake
    always_comb begin
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        if (state_reg == ST_RESP && out_free) begin
            m_tvalid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // item, staged result and output words
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            mode_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_W-1:0];
            pay_reg  <= s_tdata[KEY_W +: PAYLOAD_BITS];
        end
        res_code_reg <= res_code_next;
        res_idx_reg  <= res_idx_next;
        res_key_reg  <= res_key_next;
        res_pay_reg  <= res_pay_next;
        if (state_reg == ST_RESP && out_free) begin
            m_code_reg <= res_code_reg;
            m_idx_reg  <= res_idx_reg;
            m_key_reg  <= res_key_reg;
            m_pay_reg  <= res_pay_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_code_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, m_pay_reg, m_key_reg, m_idx_reg};

    // upper input padding carries nothing
    logic unused_pad;
    assign unused_pad = ^s_tdata[IN_W-1:0];

endmodule

/* tb/sv/oaht_table_checker.sv */
// reply checker for the hash table core: mirrors the table and compares every reply word
module oaht_table_checker import oaht_pkg::*; #(
    parameter int TABLE_BITS   = 13,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [((KEY_W+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,   // key, payload
    input  logic [MODE_W-1:0]           s_tuser,               // mode
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [((TABLE_BITS+KEY_W+FOUND_PAY_W+7)/8)*8-1:0] m_tdata,
                                                // slot_index, found_key, found_payload
    input  logic [CODE_W-1:0]           m_tuser,               // result_code
    output int                          pending,
    output int                          mismatches,
    output int                          replies_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 1 << TABLE_BITS;

    typedef struct packed {
        logic [CODE_W-1:0]      code;
        logic [TABLE_BITS-1:0]  slot;
        logic [KEY_W-1:0]       fkey;
        logic [FOUND_PAY_W-1:0] fpay;
    } reply_t;

    // mirrored table contents
    logic [STATUS_W-1:0]     st_mem  [SLOTS];
    logic [KEY_W-1:0]        key_mem [SLOTS];
    logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
    int unsigned             stored;

    reply_t awaited_replies[$];
    int     errs;
    int     seen;

    function automatic logic [TABLE_BITS-1:0] home_of(input logic [KEY_W-1:0] key);
        logic [31:0] prod;
        prod = {1'b0, key} * HASH_MULT;
        return prod[31 -: TABLE_BITS];
    endfunction

    function automatic logic [TABLE_BITS-1:0] probe_at(input logic [TABLE_BITS-1:0] home,
                                                       input int unsigned step);
        logic [31:0] sum;
        sum = 32'(home) + PROBE_STEP * step * step;
        return sum[TABLE_BITS-1:0];
    endfunction

    // search stops at a free slot, passes over deleted ones
    function automatic bit find_slot(input logic [KEY_W-1:0] key,
                                     output logic [TABLE_BITS-1:0] at);
        logic [TABLE_BITS-1:0] home;
        logic [TABLE_BITS-1:0] p;
        home = home_of(key);
        at = '0;
        for (int unsigned i = 0; i < SLOTS; i++) begin
            p = probe_at(home, i);
            if (st_mem[p] == SLOT_FREE) begin
                return 1'b0;
            end
            if (st_mem[p] == SLOT_OCCUPIED && key_mem[p] == key) begin
                at = p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic reply_t apply_table_op(input logic [MODE_W-1:0] mode,
                                              input logic [KEY_W-1:0] key,
                                              input logic [PAYLOAD_BITS-1:0] pay);
        reply_t r;
        logic [TABLE_BITS-1:0] home;
        logic [TABLE_BITS-1:0] at;
        bit got;
        r = '0;
        at = '0;
        got = 1'b0;
        case (mode)
            MODE_INSERT: begin
                if (stored >= SLOTS) begin
                    r.code = RC_FULL;
                end else begin
                    home = home_of(key);
                    for (int unsigned i = 0; i < SLOTS && !got; i++) begin
                        at = probe_at(home, i);
                        got = (st_mem[at] != SLOT_OCCUPIED);
                    end
                    if (got) begin
                        st_mem[at]  = SLOT_OCCUPIED;
                        key_mem[at] = key;
                        pay_mem[at] = pay;
                        stored++;
                        r.slot = at;
                    end else begin
                        r.code = RC_NO_SLOT;
                    end
                end
            end
            MODE_LOOKUP: begin
                if (find_slot(key, at)) begin
                    r.slot = at;
                    r.fkey = key_mem[at];
                    r.fpay = FOUND_PAY_W'(pay_mem[at]);
                end else begin
                    r.code = RC_NOT_FOUND;
                end
            end
            MODE_WITHDRAW: begin
                if (stored == 0) begin
                    r.code = RC_EMPTY;
                end else if (find_slot(key, at)) begin
                    st_mem[at] = SLOT_DELETED;
                    stored--;
                    r.slot = at;
                end else begin
                    r.code = RC_NOT_FOUND;
                end
            end
            default: begin
                // unused mode leaves the table alone and answers all zero
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        logic [TABLE_BITS-1:0]  got_slot;
        logic [KEY_W-1:0]       got_key;
        logic [FOUND_PAY_W-1:0] got_pay;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                st_mem[i] = SLOT_FREE;
            end
            stored = 0;
            awaited_replies.delete();
        end else begin
            // drain the reply side first: a word accepted now answers an older request
            if (m_tvalid && m_tready) begin
                seen++;
                got_slot = m_tdata[TABLE_BITS-1:0];
                got_key  = m_tdata[TABLE_BITS +: KEY_W];
                got_pay  = m_tdata[TABLE_BITS+KEY_W +: FOUND_PAY_W];
                if (awaited_replies.size() == 0) begin
                    $error("reply word with nothing outstanding: code %0d slot %0d",
                           m_tuser, got_slot);
                    errs++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_tuser !== want.code) begin
                        $error("result_code: expected %0d, got %0d", want.code, m_tuser);
                        errs++;
                    end
                    if (got_slot !== want.slot) begin
                        $error("slot_index: expected %0d, got %0d", want.slot, got_slot);
                        errs++;
                    end
                    if (got_key !== want.fkey) begin
                        $error("found_key: expected 0x%08h, got 0x%08h", want.fkey, got_key);
                        errs++;
                    end
                    if (got_pay !== want.fpay) begin
                        $error("found_payload: expected 0x%08h, got 0x%08h",
                               want.fpay, got_pay);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_replies.push_back(apply_table_op(s_tuser, s_tdata[KEY_W-1:0],
                                                         s_tdata[KEY_W +: PAYLOAD_BITS]));
            end
        end
        pending      <= awaited_replies.size();
        mismatches   <= errs;
        replies_seen <= seen;
    end

endmodule

/* tb/sv/tb_top.sv */
// testbench top for the hash table core: request stimulus, reply back-pressure and verdict
module tb_top import oaht_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_BITS   = 13;
    localparam int PAYLOAD_BITS = 32;
    localparam int S_DATA_W     = ((KEY_W+PAYLOAD_BITS+7)/8)*8;
    localparam int M_DATA_W     = ((TABLE_BITS+KEY_W+FOUND_PAY_W+7)/8)*8;

    // mode value with no operation behind it
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int     CHURN_ITEMS   = 1100;
    localparam int     HOT_HOMES     = 8;
    localparam int     POOL_CAP      = 400;
    localparam int     SETTLE_CYCLES = 64;
    localparam longint CYCLE_LIMIT   = 8_000_000;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata;    // key, payload
    logic [MODE_W-1:0]       s_tuser;    // mode
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;    // slot_index, found_key, found_payload
    logic [CODE_W-1:0]       m_tuser;    // result_code

    int     pending;
    int     mismatches;
    int     replies_seen;
    int     words_sent;
    int     ready_left;
    longint cycle_count = 0;

    logic [31:0]           hash_inv;
    logic [KEY_W-1:0]      live_keys[$];
    logic [TABLE_BITS-1:0] hot_home [HOT_HOMES];

    always #2 aclk = ~aclk;

    open_addressing_hash_table_core #(
        .TABLE_BITS   (TABLE_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    oaht_table_checker #(
        .TABLE_BITS   (TABLE_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .pending      (pending),
        .mismatches   (mismatches),
        .replies_seen (replies_seen)
    );

    // reply back-pressure: short stalls mostly, a long one now and then,
    // and long ready stretches with no stall at all
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (m_tready) begin
            m_tready   <= 1'b0;
            ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
        end else begin
            m_tready   <= 1'b1;
            ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(0, 12);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // key whose hash lands in the given home slot, built through the inverse multiplier
    function automatic logic [KEY_W-1:0] key_with_home(input logic [TABLE_BITS-1:0] home);
        logic [31:0] k;
        do begin
            k = {home, (32-TABLE_BITS)'($urandom())} * hash_inv;
        end while (k[31]);
        return k[KEY_W-1:0];
    endfunction

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                             input logic [PAYLOAD_BITS-1:0] pay);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap  = (pick < 55) ? 0 :
               (pick < 85) ? $urandom_range(1, 3) :
               (pick < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
        if (gap > 0) begin
            // idle with junk on the data lines
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'({$urandom(), $urandom()});
            s_tuser  <= MODE_W'($urandom());
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_DATA_W'({pay, key});
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // hold the request side until every reply is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        logic [KEY_W-1:0]      ka;
        logic [KEY_W-1:0]      kb;
        logic [KEY_W-1:0]      kc;
        logic [KEY_W-1:0]      kd;
        logic [KEY_W-1:0]      k;
        logic [TABLE_BITS-1:0] crowd;
        int pick;
        int idx;

        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        aresetn     <= 1'b0;

        // inverse of the hash multiplier mod 2^32 by newton steps
        hash_inv = HASH_MULT;
        repeat (5) hash_inv = hash_inv * (32'd2 - HASH_MULT * hash_inv);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, collisions, duplicates, deleted slots
        send_word(MODE_WITHDRAW, KEY_W'($urandom()), $urandom());   // empty table
        send_word(MODE_LOOKUP, '0, '0);                             // miss on first free slot
        send_word(MODE_SPARE, '1, '1);
        send_word(MODE_INSERT, '0, '0);
        send_word(MODE_INSERT, '1, '1);
        send_word(MODE_LOOKUP, '1, '0);
        send_word(MODE_LOOKUP, '0, '1);
        crowd = TABLE_BITS'($urandom());
        ka = key_with_home(crowd);
        kb = key_with_home(crowd);
        kc = key_with_home(crowd);
        kd = key_with_home(crowd);
        send_word(MODE_INSERT, ka, $urandom());
        send_word(MODE_INSERT, kb, $urandom());
        send_word(MODE_INSERT, kc, $urandom());
        send_word(MODE_INSERT, ka, $urandom());     // same key stored twice
        send_word(MODE_WITHDRAW, kb, $urandom());
        send_word(MODE_LOOKUP, kc, $urandom());     // probes past the deleted slot
        send_word(MODE_LOOKUP, kb, $urandom());     // deleted, then runs to a free slot
        send_word(MODE_WITHDRAW, ka, $urandom());
        send_word(MODE_LOOKUP, ka, $urandom());     // finds the second copy
        send_word(MODE_INSERT, kd, $urandom());     // reuses a deleted slot
        send_word(MODE_WITHDRAW, kb, $urandom());   // miss with entries present
        send_word(MODE_WITHDRAW, '1, '0);
        send_word(MODE_WITHDRAW, '0, '0);
        send_word(MODE_WITHDRAW, kc, $urandom());
        send_word(MODE_WITHDRAW, ka, $urandom());
        send_word(MODE_WITHDRAW, kd, $urandom());
        send_word(MODE_WITHDRAW, ka, $urandom());   // table empty again
        wait_drained();

        // churn: most keys crowd into a few homes so chains get long
        for (int i = 0; i < HOT_HOMES; i++) begin
            hot_home[i] = TABLE_BITS'($urandom());
        end
        for (int n = 0; n < CHURN_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (live_keys.size() == 0 || (pick < 35 && live_keys.size() < POOL_CAP)) begin
                k = ($urandom_range(0, 9) < 7) ?
                    key_with_home(hot_home[$urandom_range(0, HOT_HOMES-1)]) :
                    KEY_W'($urandom());
                live_keys.push_back(k);
                send_word(MODE_INSERT, k, $urandom());
            end else if (pick < 60) begin
                send_word(MODE_LOOKUP, live_keys[$urandom_range(0, live_keys.size()-1)],
                          $urandom());
            end else if (pick < 80) begin
                idx = $urandom_range(0, live_keys.size()-1);
                k = live_keys[idx];
                live_keys.delete(idx);
                send_word(MODE_WITHDRAW, k, $urandom());
            end else if (pick < 92) begin
                send_word(MODE_LOOKUP, key_with_home(hot_home[$urandom_range(0, HOT_HOMES-1)]),
                          $urandom());
            end else if (pick < 97) begin
                send_word(MODE_WITHDRAW,
                          key_with_home(hot_home[$urandom_range(0, HOT_HOMES-1)]), $urandom());
            end else begin
                send_word(MODE_SPARE, KEY_W'($urandom()), $urandom());
            end
            if ($urandom_range(0, 99) == 0) begin
                wait_drained();
            end
        end

        // empty the table, leaving only deleted and free slots
        while (live_keys.size() != 0) begin
            idx = $urandom_range(0, live_keys.size()-1);
            k = live_keys[idx];
            live_keys.delete(idx);
            send_word(MODE_WITHDRAW, k, $urandom());
        end
        send_word(MODE_LOOKUP, key_with_home(hot_home[0]), '0);   // runs over deleted slots
        send_word(MODE_WITHDRAW, KEY_W'($urandom()), '0);         // table empty again
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("sent %0d requests, checked %0d replies: empty, extreme, duplicate, collision",
                 words_sent, replies_seen);
        $display("and deleted-slot cases, churn on %0d crowded homes, then a full drain",
                 HOT_HOMES);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
